/* hdl/qte_pkg.sv */
package qte_pkg;

  localparam int QuatW = 16;
  localparam int QuatFrac = 15;
  localparam int CordicIters = 28;
  localparam int CordicW = 64;
  localparam int AngW = 34;
  localparam int SqrtSteps = 31;

  typedef logic signed [CordicW-1:0] cval_t;
  typedef logic signed [AngW-1:0] ang_t;

  function automatic ang_t atan_entry(input int i);
    ang_t r;
    r = '0;
    case (i)
      0: r = 34'sh020000000;
      1: r = 34'sh012E4051D;
      2: r = 34'sh009FB385B;
      3: r = 34'sh0051111D4;
      4: r = 34'sh0028B0D43;
      5: r = 34'sh00145D7E1;
      6: r = 34'sh000A2F61E;
      7: r = 34'sh000517C55;
      8: r = 34'sh00028BE53;
      9: r = 34'sh000145F2F;
      10: r = 34'sh0000A2F98;
      11: r = 34'sh0000517CC;
      12: r = 34'sh000028BE6;
      13: r = 34'sh0000145F3;
      14: r = 34'sh00000A2F9;
      15: r = 34'sh00000517C;
      16: r = 34'sh0000028BE;
      17: r = 34'sh00000145F;
      18: r = 34'sh000000A2F;
      19: r = 34'sh000000517;
      20: r = 34'sh00000028B;
      21: r = 34'sh000000145;
      22: r = 34'sh0000000A2;
      23: r = 34'sh000000051;
      24: r = 34'sh000000028;
      25: r = 34'sh000000014;
      26: r = 34'sh00000000A;
      27: r = 34'sh000000005;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/quaternion_to_euler_angles.sv */
// Pipeline: 66 register stages.
// Throughput: one request per cycle; the pipeline advances whenever the
// output register is empty or being taken, so a stall freezes every stage.
// Reset clears only the per-stage valid bits; data registers are not reset.
module quaternion_to_euler_angles (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_deg_o,
  output logic signed [14:0] pitch_deg_o,
  output logic signed [15:0] yaw_deg_o,
  output logic               pitch_clamped_o
);

  localparam int SqSt = qte_pkg::SqrtSteps;
  localparam int CoSt = qte_pkg::CordicIters + 2;
  localparam int Depth = 2 + SqSt + CoSt + 3;

  logic [Depth-1:0] v_q;
  logic en;
  assign en = !v_q[Depth-1] || out_ready_i;
  assign in_ready_o = en && rst_ni;
  assign out_valid_o = v_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Depth-2:0], in_valid_i};
    end
  end

  // Stage A: products.
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, xz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= quat_w_i * quat_x_i;  yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;  yy_q <= quat_y_i * quat_y_i;
      wz_q <= quat_w_i * quat_z_i;  xy_q <= quat_x_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;  wy_q <= quat_w_i * quat_y_i;
      xz_q <= quat_x_i * quat_z_i;
    end
  end

  // Stage B: sums and asin saturation.
  localparam logic signed [35:0] One = 36'sd1 <<< (2 * qte_pkg::QuatFrac);
  logic signed [35:0] rn_q, rd_q, yn_q, yd_q, s_q;
  logic cl_q;
  logic signed [35:0] sraw;
  always_comb sraw = 36'(wy_q) * 2 - 36'(xz_q) * 2;
  always_ff @(posedge clk_i) begin
    if (en) begin
      rn_q <= 36'(wx_q) * 2 + 36'(yz_q) * 2;
      rd_q <= One - 36'(xx_q) * 2 - 36'(yy_q) * 2;
      yn_q <= 36'(wz_q) * 2 + 36'(xy_q) * 2;
      yd_q <= One - 36'(yy_q) * 2 - 36'(zz_q) * 2;
      cl_q <= (sraw > One) || (sraw < -One);
      s_q  <= (sraw > One) ? One : (sraw < -One) ? -One : sraw;
    end
  end

  // Square-root pipeline for c = sqrt(2^60 - s^2), one result bit per stage.
  // The square itself is taken from a 31x31 product in the first stage.
  logic [60:0] rem_q [SqSt+1];
  logic [31:0] res_q [SqSt+1];
  logic signed [35:0] rnp_q [SqSt+1], rdp_q [SqSt+1], ynp_q [SqSt+1];
  logic signed [35:0] ydp_q [SqSt+1], sp_q [SqSt+1];
  logic clp_q [SqSt+1];
  logic [30:0] sabs;
  logic [61:0] ssq;
  always_comb begin
    sabs = s_q[35] ? 31'(-s_q) : 31'(s_q);
    ssq = 62'(sabs) * 62'(sabs);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0] <= 61'((62'd1 << 60) - ssq);
      res_q[0] <= '0;
      rnp_q[0] <= rn_q; rdp_q[0] <= rd_q; ynp_q[0] <= yn_q;
      ydp_q[0] <= yd_q; sp_q[0] <= s_q; clp_q[0] <= cl_q;
    end
  end
  for (genvar k = 0; k < SqSt; k++) begin : g_sq
    localparam int B = 2 * (SqSt - 1 - k);
    logic [62:0] trial;
    always_comb trial = (63'(res_q[k]) << (B + 2)) + (63'd1 << B);
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (63'(rem_q[k]) >= trial) begin
          rem_q[k+1] <= 61'(63'(rem_q[k]) - trial);
          res_q[k+1] <= (res_q[k] << 1) | 32'd1;
        end else begin
          rem_q[k+1] <= rem_q[k];
          res_q[k+1] <= res_q[k] << 1;
        end
        rnp_q[k+1] <= rnp_q[k]; rdp_q[k+1] <= rdp_q[k]; ynp_q[k+1] <= ynp_q[k];
        ydp_q[k+1] <= ydp_q[k]; sp_q[k+1] <= sp_q[k]; clp_q[k+1] <= clp_q[k];
      end
    end
  end

  qte_pkg::ang_t ar, ap, ay;
  qte_cordic u_roll (.clk_i, .en_i(en), .y_i(64'(rnp_q[SqSt])),
                     .x_i(64'(rdp_q[SqSt])), .ang_o(ar));
  qte_cordic u_pitch (.clk_i, .en_i(en), .y_i(64'(sp_q[SqSt])),
                      .x_i(64'(res_q[SqSt])), .ang_o(ap));
  qte_cordic u_yaw (.clk_i, .en_i(en), .y_i(64'(ynp_q[SqSt])),
                    .x_i(64'(ydp_q[SqSt])), .ang_o(ay));

  logic cl_line_q [CoSt];
  always_ff @(posedge clk_i) begin
    if (en) begin
      cl_line_q[0] <= clp_q[SqSt];
      for (int j = 1; j < CoSt; j++) cl_line_q[j] <= cl_line_q[j-1];
    end
  end

  // Degree scaling: multiply by 360*128 then round.
  logic signed [51:0] mr_q, mp_q, my_q;
  logic cl2_q, cl3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      mr_q <= 52'(ar) * 52'sd46080 + (52'sd1 <<< 31);
      mp_q <= 52'(ap) * 52'sd46080 + (52'sd1 <<< 31);
      my_q <= 52'(ay) * 52'sd46080 + (52'sd1 <<< 31);
      cl2_q <= cl_line_q[CoSt-1];
    end
  end

  function automatic logic signed [19:0] lim(input logic signed [51:0] m,
                                             input logic signed [19:0] l);
    logic signed [19:0] v;
    v = 20'(m >>> 32);
    if (v > l) v = l;
    if (v < -l) v = -l;
    return v;
  endfunction

  logic signed [19:0] r3, p3, y3;
  always_comb begin
    r3 = lim(mr_q, 20'sd23040);
    p3 = lim(mp_q, 20'sd11520);
    y3 = lim(my_q, 20'sd23040);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_deg_o <= 16'(r3);
      pitch_deg_o <= 15'(p3);
      yaw_deg_o <= 16'(y3);
      cl3_q <= cl2_q;
    end
  end
  assign pitch_clamped_o = cl3_q;

endmodule

/* hdl/qte_cordic.sv */
module qte_cordic (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  qte_pkg::cval_t       y_i,
  input  qte_pkg::cval_t       x_i,
  output qte_pkg::ang_t        ang_o
);

  localparam int N = qte_pkg::CordicIters;
  localparam int W = qte_pkg::CordicW;

  // Stage 0: quadrant fold. Stage 1: normalize. Stages 2..N+1: iterations.
  qte_pkg::cval_t x0_q, y0_q;
  qte_pkg::ang_t  z0_q;
  logic           zero0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero0_q <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x0_q <= -x_i;
        y0_q <= -y_i;
        z0_q <= (y_i >= 0) ? qte_pkg::AngW'(64'sh80000000)
                           : -qte_pkg::AngW'(64'sh80000000);
      end else begin
        x0_q <= x_i;
        y0_q <= y_i;
        z0_q <= '0;
      end
    end
  end

  logic [W-1:0] ax, ay, mx;
  logic [5:0]   sh;
  always_comb begin
    ax = x0_q[W-1] ? W'(-x0_q) : W'(x0_q);
    ay = y0_q[W-1] ? W'(-y0_q) : W'(y0_q);
    mx = (ax > ay) ? ax : ay;
    sh = '0;
    for (int b = 0; b < 60; b++) begin
      if (mx[b]) sh = 6'(59 - b);
    end
    if (mx[W-1:59] != '0) sh = '0;
  end

  qte_pkg::cval_t xs_q [N+1];
  qte_pkg::cval_t ys_q [N+1];
  qte_pkg::ang_t  zs_q [N+1];
  logic           zs0_q [N+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xs_q[0]  <= x0_q <<< sh;
      ys_q[0]  <= y0_q <<< sh;
      zs_q[0]  <= z0_q;
      zs0_q[0] <= zero0_q;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zs0_q[i+1] <= zs0_q[i];
        if (ys_q[i] >= 0) begin
          xs_q[i+1] <= xs_q[i] + (ys_q[i] >>> i);
          ys_q[i+1] <= ys_q[i] - (xs_q[i] >>> i);
          zs_q[i+1] <= zs_q[i] + qte_pkg::atan_entry(i);
        end else begin
          xs_q[i+1] <= xs_q[i] - (ys_q[i] >>> i);
          ys_q[i+1] <= ys_q[i] + (xs_q[i] >>> i);
          zs_q[i+1] <= zs_q[i] - qte_pkg::atan_entry(i);
        end
      end
    end
  end

  assign ang_o = zs0_q[N] ? '0 : zs_q[N];

endmodule
